/* hdl/jhs3d_pkg.sv */
// shared constants and types for the 3d jacobi heat stencil
// no dependencies; imported by jacobi_heat_stencil_3d
package jhs3d_pkg;

  localparam int DEF_MAX_ROWS   = 128;
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_TEMP_WIDTH = 16;

  localparam int GRID_X_W   = 16;
  localparam int GRID_Y_W   = 8;
  localparam int GRID_Z_W   = 7;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [GRID_X_W-1:0] GRID_X_RST = 16'd1000;
  localparam logic [GRID_Y_W-1:0] GRID_Y_RST = 8'd100;
  localparam logic [GRID_Z_W-1:0] GRID_Z_RST = 7'd50;

  localparam int MIN_DIM     = 3;
  localparam int STENCIL_DIV = 6;
  localparam int FIFO_DEPTH  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_X,
    REG_GRID_Y,
    REG_GRID_Z
  } cfg_reg_e;

endpackage

/* hdl/jacobi_heat_stencil_3d.sv */
// top level of the 3d jacobi heat stencil: plane stores, averaging pipeline, result fifo
// depends on jhs3d_pkg
//
// Takes one Q8.8 grid point per cycle while in_ready_o is high, in raster order (plane,
// row, point), and returns the updated value of the point one plane behind, for planes 1
// to nx-2; y and z border points pass through. Each accepted point's result is registered
// through the pipeline into the output fifo; the rate is set by the plane stores, which
// are read and written once per point: the older plane store with two read ports, the
// previous plane store split into even and odd column banks with two read ports each.
// Accesses to the entry written by the point just before are forwarded. in_ready_o drops
// only while eight results are owed to the output side. The plane stores are not cleared
// after reset and need two full planes of history before results are meaningful.
module jacobi_heat_stencil_3d
  import jhs3d_pkg::*;
#(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int TEMP_WIDTH = DEF_TEMP_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TEMP_WIDTH-1:0] temperature_i,
  input  logic                  grid_start_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [TEMP_WIDTH-1:0] new_temperature_o,
  output logic                  sweep_end_o
);

  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int NY_W       = $clog2(MAX_ROWS + 1);
  localparam int NZ_W       = $clog2(MAX_COLS + 1);
  localparam int CELLS      = MAX_ROWS * MAX_COLS;
  localparam int CELL_W     = $clog2(CELLS);
  localparam int HALF_COLS  = (MAX_COLS + 1) / 2;
  localparam int BANK_DEPTH = MAX_ROWS * HALF_COLS;
  localparam int BANK_W     = $clog2(BANK_DEPTH);
  localparam int SUM_W      = TEMP_WIDTH + 3;
  localparam int RECIP_SH   = SUM_W;
  localparam int RECIP_W    = SUM_W - 2;
  localparam int PROD_W     = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / 64'(STENCIL_DIV));
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // configuration
  logic [GRID_X_W-1:0] grid_x_q;
  logic [GRID_Y_W-1:0] grid_y_q;
  logic [GRID_Z_W-1:0] grid_z_q;
  logic [GRID_X_W-1:0] nx;
  logic [NY_W-1:0]     ny;
  logic [NZ_W-1:0]     nz;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_x_q <= GRID_X_RST;
      grid_y_q <= GRID_Y_RST;
      grid_z_q <= GRID_Z_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GRID_X: grid_x_q <= cfg_data_i[GRID_X_W-1:0];
        REG_GRID_Y: grid_y_q <= cfg_data_i[GRID_Y_W-1:0];
        REG_GRID_Z: grid_z_q <= cfg_data_i[GRID_Z_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nx = (grid_x_q < GRID_X_W'(MIN_DIM)) ? GRID_X_W'(MIN_DIM) : grid_x_q;
    if (grid_y_q < GRID_Y_W'(MIN_DIM)) begin
      ny = NY_W'(MIN_DIM);
    end else if (32'(grid_y_q) > 32'(MAX_ROWS)) begin
      ny = NY_W'(MAX_ROWS);
    end else begin
      ny = NY_W'(grid_y_q);
    end
    if (grid_z_q < GRID_Z_W'(MIN_DIM)) begin
      nz = NZ_W'(MIN_DIM);
    end else if (32'(grid_z_q) > 32'(MAX_COLS)) begin
      nz = NZ_W'(MAX_COLS);
    end else begin
      nz = NZ_W'(grid_z_q);
    end
  end

  // position and stage 0
  logic [GRID_X_W-1:0] pos_x_q, pos_x_d;
  logic [ROW_W-1:0]    pos_y_q, pos_y_d;
  logic [COL_W-1:0]    pos_z_q, pos_z_d;
  logic [GRID_X_W-1:0] x0;
  logic [ROW_W-1:0]    y0;
  logic [COL_W-1:0]    z0;
  logic [GRID_X_W:0]   x_p1;
  logic [GRID_X_W:0]   nx_ext;
  logic [NY_W-1:0]     y_p1;
  logic [NZ_W-1:0]     z_p1;
  logic                emit0, border0, end0;
  logic                in_acc;

  logic [CELL_W-1:0]   addr_c, addr_up, addr_right, addr_down;
  logic [BANK_W-1:0]   ba_own, ba_right, ba_down;
  logic [BANK_W-1:0]   pe_addr0, po_addr0;

  always_comb begin
    x0     = grid_start_i ? '0 : pos_x_q;
    y0     = grid_start_i ? '0 : pos_y_q;
    z0     = grid_start_i ? '0 : pos_z_q;
    x_p1   = {1'b0, x0} + (GRID_X_W + 1)'(1);
    nx_ext = {1'b0, nx};
    y_p1   = NY_W'(y0) + NY_W'(1);
    z_p1   = NZ_W'(z0) + NZ_W'(1);

    emit0   = (x0 >= GRID_X_W'(2)) && (x_p1 <= nx_ext);
    border0 = (y0 == '0) || (y_p1 >= ny) || (z0 == '0) || (z_p1 >= nz);
    end0    = (x_p1 == nx_ext) && (y_p1 == ny) && (z_p1 == nz);

    pos_x_d = x0;
    pos_y_d = y0;
    pos_z_d = z0;
    if (z_p1 >= nz) begin
      pos_z_d = '0;
      if (y_p1 >= ny) begin
        pos_y_d = '0;
        pos_x_d = (x_p1 >= nx_ext) ? '0 : x_p1[GRID_X_W-1:0];
      end else begin
        pos_y_d = y_p1[ROW_W-1:0];
      end
    end else begin
      pos_z_d = z_p1[COL_W-1:0];
    end

    addr_c     = CELL_W'(y0 * MAX_COLS + z0);
    addr_up    = CELL_W'(y0 * MAX_COLS + z0 - MAX_COLS);
    addr_right = CELL_W'(y0 * MAX_COLS + z0 + 1);
    addr_down  = CELL_W'((y0 + 1) * MAX_COLS + z0);
    ba_own     = BANK_W'(y0 * HALF_COLS + (z0 >> 1));
    ba_right   = BANK_W'(y0 * HALF_COLS + ((z0 + 1) >> 1));
    ba_down    = BANK_W'((y0 + 1) * HALF_COLS + (z0 >> 1));
    pe_addr0   = z0[0] ? ba_right : ba_own;
    po_addr0   = z0[0] ? ba_own : ba_right;
  end

  // stage 1 registers
  logic                  s1_act_q, s1_emit_q;
  logic                  s1_end_q, s1_border_q, s1_par_q;
  logic [TEMP_WIDTH-1:0] s1_t_q;
  logic [CELL_W-1:0]     s1_addr_q;
  logic [BANK_W-1:0]     s1_ba_q;
  logic [TEMP_WIDTH-1:0] s1_left_q;
  logic                  fwd_c_q, fwd_up_q, fwd_r_q, fwd_d_q;
  logic [TEMP_WIDTH-1:0] fwd_ov_q, fwd_pv_q;
  logic [TEMP_WIDTH-1:0] last_centre_q;
  logic [TEMP_WIDTH-1:0] left0;

  logic [TEMP_WIDTH-1:0] o_rd0_q, o_rd1_q;
  logic [TEMP_WIDTH-1:0] pe_rd0_q, pe_rd1_q, po_rd0_q, po_rd1_q;
  logic [TEMP_WIDTH-1:0] centre, older_c, older_up, prev_right, prev_down;
  logic [TEMP_WIDTH-1:0] own_c, own_d, other_r;
  logic [SUM_W-1:0]      sum1;

  // plane stores
  logic [TEMP_WIDTH-1:0] older_mem [CELLS];
  logic [TEMP_WIDTH-1:0] pe_mem [BANK_DEPTH];
  logic [TEMP_WIDTH-1:0] po_mem [BANK_DEPTH];

  logic [CNT_W-1:0] fifo_cnt_q;
  logic             s2_emit_q, s3_emit_q;
  logic [CNT_W:0]   owed;

  assign owed       = (CNT_W + 1)'(fifo_cnt_q) + (CNT_W + 1)'(s1_emit_q)
                    + (CNT_W + 1)'(s2_emit_q) + (CNT_W + 1)'(s3_emit_q);
  assign in_ready_o = (owed < (CNT_W + 1)'(FIFO_DEPTH));
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      pos_z_q   <= '0;
      s1_act_q  <= 1'b0;
      s1_emit_q <= 1'b0;
    end else begin
      s1_act_q  <= in_acc;
      s1_emit_q <= in_acc && emit0;
      if (in_acc) begin
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
        pos_z_q <= pos_z_d;
      end
    end
  end

  assign left0 = s1_act_q ? centre : last_centre_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_t_q      <= temperature_i;
      s1_end_q    <= end0;
      s1_border_q <= border0;
      s1_par_q    <= z0[0];
      s1_addr_q   <= addr_c;
      s1_ba_q     <= ba_own;
      s1_left_q   <= left0;
      fwd_c_q     <= s1_act_q && (s1_addr_q == addr_c);
      fwd_up_q    <= s1_act_q && (s1_addr_q == addr_up);
      fwd_r_q     <= s1_act_q && (s1_addr_q == addr_right);
      fwd_d_q     <= s1_act_q && (s1_addr_q == addr_down);
      fwd_ov_q    <= centre;
      fwd_pv_q    <= s1_t_q;
    end
    if (s1_act_q) begin
      last_centre_q <= centre;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_act_q) begin
      older_mem[s1_addr_q] <= centre;
    end
    if (in_acc) begin
      o_rd0_q <= older_mem[addr_c];
      o_rd1_q <= older_mem[addr_up];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_act_q && !s1_par_q) begin
      pe_mem[s1_ba_q] <= s1_t_q;
    end
    if (in_acc) begin
      pe_rd0_q <= pe_mem[pe_addr0];
      pe_rd1_q <= pe_mem[ba_down];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_act_q && s1_par_q) begin
      po_mem[s1_ba_q] <= s1_t_q;
    end
    if (in_acc) begin
      po_rd0_q <= po_mem[po_addr0];
      po_rd1_q <= po_mem[ba_down];
    end
  end

  always_comb begin
    own_c      = s1_par_q ? po_rd0_q : pe_rd0_q;
    own_d      = s1_par_q ? po_rd1_q : pe_rd1_q;
    other_r    = s1_par_q ? pe_rd0_q : po_rd0_q;
    centre     = fwd_c_q  ? fwd_pv_q : own_c;
    older_c    = fwd_c_q  ? fwd_ov_q : o_rd0_q;
    older_up   = fwd_up_q ? fwd_ov_q : o_rd1_q;
    prev_right = fwd_r_q  ? fwd_pv_q : other_r;
    prev_down  = fwd_d_q  ? fwd_pv_q : own_d;
    sum1 = SUM_W'(s1_t_q) + SUM_W'(older_c) + SUM_W'(older_up) + SUM_W'(s1_left_q)
         + SUM_W'(prev_down) + SUM_W'(prev_right);
  end

  // stage 2: sum registered, reciprocal multiply
  logic                  s2_end_q, s2_border_q;
  logic [TEMP_WIDTH-1:0] s2_centre_q;
  logic [SUM_W-1:0]      s2_sum_q;

  // stage 3: product registered, correction
  logic                  s3_end_q, s3_border_q;
  logic [TEMP_WIDTH-1:0] s3_centre_q;
  logic [SUM_W-1:0]      s3_sum_q;
  logic [PROD_W-1:0]     s3_prod_q;
  logic [RECIP_W-1:0]    q_est;
  logic [SUM_W-1:0]      rem;
  logic [RECIP_W-1:0]    q_fix;
  logic [TEMP_WIDTH-1:0] result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_emit_q <= 1'b0;
      s3_emit_q <= 1'b0;
    end else begin
      s2_emit_q <= s1_emit_q;
      s3_emit_q <= s2_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_end_q    <= s1_end_q;
    s2_border_q <= s1_border_q;
    s2_centre_q <= centre;
    s2_sum_q    <= sum1;
    s3_end_q    <= s2_end_q;
    s3_border_q <= s2_border_q;
    s3_centre_q <= s2_centre_q;
    s3_sum_q    <= s2_sum_q;
    s3_prod_q   <= PROD_W'(s2_sum_q) * PROD_W'(RECIP);
  end

  always_comb begin
    q_est  = s3_prod_q[PROD_W-1:RECIP_SH];
    rem    = s3_sum_q - SUM_W'(q_est) * SUM_W'(STENCIL_DIV);
    q_fix  = (rem >= SUM_W'(STENCIL_DIV)) ? q_est + RECIP_W'(1) : q_est;
    result = s3_border_q ? s3_centre_q : TEMP_WIDTH'(q_fix);
  end

  // result fifo
  logic [TEMP_WIDTH-1:0] fifo_temp_q [FIFO_DEPTH];
  logic                  fifo_end_q  [FIFO_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic                  fifo_push, fifo_pop;

  assign fifo_push = s3_emit_q;
  assign fifo_pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (fifo_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (fifo_push && !fifo_pop) begin
        fifo_cnt_q <= fifo_cnt_q + CNT_W'(1);
      end else if (!fifo_push && fifo_pop) begin
        fifo_cnt_q <= fifo_cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_push) begin
      fifo_temp_q[wr_ptr_q] <= result;
      fifo_end_q[wr_ptr_q]  <= s3_end_q;
    end
  end

  assign out_valid_o       = (fifo_cnt_q != '0);
  assign new_temperature_o = fifo_temp_q[rd_ptr_q];
  assign sweep_end_o       = fifo_end_q[rd_ptr_q];

  // checks
  a_fifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push && !fifo_pop |-> fifo_cnt_q < CNT_W'(FIFO_DEPTH))
    else $error("result fifo overflow");

  a_owed_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    owed <= (CNT_W + 1)'(FIFO_DEPTH))
    else $error("more results owed than fifo entries");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |=> out_valid_o)
    else $error("pushed result not visible");

  a_emit_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_emit_q |-> s1_act_q)
    else $error("result flagged without an accepted transaction");

endmodule

/* tb/tb_top.sv */
// self-checking testbench for jacobi_heat_stencil_3d: streams grids through the valid/ready
// ports and checks each result against a scoreboard class that predicts one jacobi sweep
// depends on jhs3d_pkg and jacobi_heat_stencil_3d
module tb_top;
  import jhs3d_pkg::*;

  localparam int TEMP_W        = DEF_TEMP_WIDTH;
  localparam int PLANE_PTS     = DEF_MAX_ROWS * DEF_MAX_COLS;
  localparam int MAX_GAP       = 19;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 12;
  localparam int TOTAL_POINTS  = 1700;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [TEMP_W-1:0] new_temp;
    logic              sweep_end;
  } point_result_t;

  class stencil_scoreboard;
    logic [TEMP_W-1:0]   near_plane [PLANE_PTS];
    logic [TEMP_W-1:0]   far_plane  [PLANE_PTS];
    int unsigned         px, py, pz;
    logic [GRID_X_W-1:0] gx;
    logic [GRID_Y_W-1:0] gy;
    logic [GRID_Z_W-1:0] gz;
    point_result_t       owed_points [$];
    int unsigned         accepted;
    int unsigned         errors;

    function new();
      gx = GRID_X_RST;
      gy = GRID_Y_RST;
      gz = GRID_Z_RST;
      px = 0;
      py = 0;
      pz = 0;
      accepted = 0;
      errors = 0;
      foreach (near_plane[i]) begin
        near_plane[i] = '0;
        far_plane[i] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GRID_X: gx = data[GRID_X_W-1:0];
        REG_GRID_Y: gy = data[GRID_Y_W-1:0];
        REG_GRID_Z: gz = data[GRID_Z_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned dim_x();
      return (gx < MIN_DIM) ? MIN_DIM : gx;
    endfunction

    function int unsigned dim_y();
      if (gy < MIN_DIM) return MIN_DIM;
      if (gy > DEF_MAX_ROWS) return DEF_MAX_ROWS;
      return gy;
    endfunction

    function int unsigned dim_z();
      if (gz < MIN_DIM) return MIN_DIM;
      if (gz > DEF_MAX_COLS) return DEF_MAX_COLS;
      return gz;
    endfunction

    function int unsigned grid_points();
      return dim_x() * dim_y() * dim_z();
    endfunction

    function bit at_origin();
      return px == 0 && py == 0 && pz == 0;
    endfunction

    function int unsigned plane_index(int unsigned y, int unsigned z);
      return (y * DEF_MAX_COLS + z) % PLANE_PTS;
    endfunction

    function void note_point(logic [TEMP_W-1:0] t, logic s);
      int unsigned   nx, ny, nz, x, y, z, c, sum;
      point_result_t r;
      nx = dim_x();
      ny = dim_y();
      nz = dim_z();
      accepted++;
      if (s) begin
        px = 0;
        py = 0;
        pz = 0;
      end
      x = px;
      y = py;
      z = pz;
      c = plane_index(y, z);
      if (x >= 2 && x <= nx - 1) begin
        if (y == 0 || y >= ny - 1 || z == 0 || z >= nz - 1) begin
          r.new_temp = near_plane[c];
        end else begin
          sum = t + far_plane[c] + far_plane[plane_index(y - 1, z)]
              + far_plane[plane_index(y, z - 1)] + near_plane[plane_index(y + 1, z)]
              + near_plane[plane_index(y, z + 1)];
          r.new_temp = TEMP_W'(sum / STENCIL_DIV);
        end
        r.sweep_end = (x == nx - 1 && y == ny - 1 && z == nz - 1);
        owed_points.push_back(r);
      end
      far_plane[c] = near_plane[c];
      near_plane[c] = t;
      if (z + 1 >= nz) begin
        pz = 0;
        if (y + 1 >= ny) begin
          py = 0;
          px = (x + 1 >= nx) ? 0 : ((x + 1) & 32'hFFFF);
        end else begin
          py = y + 1;
        end
      end else begin
        pz = z + 1;
      end
    endfunction

    function void check_point(logic [TEMP_W-1:0] t, logic e);
      point_result_t r;
      if (owed_points.size() == 0) begin
        $error("result with no expectation waiting: new_temperature %h sweep_end %b", t, e);
        errors++;
        return;
      end
      r = owed_points.pop_front();
      if (t !== r.new_temp) begin
        $error("new_temperature: expected %h, actual %h", r.new_temp, t);
        errors++;
      end
      if (e !== r.sweep_end) begin
        $error("sweep_end: expected %b, actual %b", r.sweep_end, e);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_points.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [TEMP_W-1:0]     temperature_i = '0;
  logic                  grid_start_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [TEMP_W-1:0]     new_temperature_o;
  logic                  sweep_end_o;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_req = 1'b0;

  stencil_scoreboard sweep_sb = new();

  jacobi_heat_stencil_3d DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .temperature_i    (temperature_i),
    .grid_start_i     (grid_start_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .new_temperature_o(new_temperature_o),
    .sweep_end_o      (sweep_end_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [TEMP_W-1:0] pick_temp();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return TEMP_W'($urandom);
    endcase
  endfunction

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sweep_sb.write_reg(idx, data);
  endtask

  task automatic write_grid(int unsigned ax, int unsigned ay, int unsigned az, bit stray);
    logic [7:0] junk_y;
    logic [8:0] junk_z;
    junk_y = 8'($urandom);
    junk_z = 9'($urandom);
    put_reg(REG_GRID_X, ax[GRID_X_W-1:0]);
    put_reg(REG_GRID_Y, {junk_y, ay[GRID_Y_W-1:0]});
    if (stray) put_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    put_reg(REG_GRID_Z, {junk_z, az[GRID_Z_W-1:0]});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_point(logic [TEMP_W-1:0] t, logic s);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    temperature_i <= t;
    grid_start_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sweep_sb.note_point(t, s);
  endtask

  task automatic run_points(int unsigned n, bit first_start, bit allow_restart);
    logic s;
    for (int unsigned i = 0; i < n; i++) begin
      s = (i == 0) ? first_start : (allow_restart && $urandom_range(0, 299) == 0);
      send_point(pick_temp(), s);
    end
  endtask

  task automatic run_to_origin();
    do send_point(pick_temp(), 1'b0); while (!sweep_sb.at_origin());
  endtask

  // all results back and pipeline empty before any register write
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sweep_sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned ay, az, span;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest grid, points on the middle row or column (incl. the single interior point) at full scale, the rest zero
    write_grid(3, 3, 3, 1'b1);
    for (int unsigned k = 0; k < 27; k++) begin
      ay = (k / 3) % 3;
      az = k % 3;
      send_point(((ay != 1) && (az != 1)) ? 16'h0000 : 16'hFFFF, k == 0);
    end
    settle();

    // sizes below minimum clamp to 3, second grid follows by wrap
    write_grid(0, 0, 0, 1'b0);
    run_points(2 * sweep_sb.grid_points(), 1'b0, 1'b0);
    settle();

    // widest x, then shrink x with the position past the new border
    write_grid(65535, 3, 3, 1'b0);
    run_points(54, 1'b1, 1'b0);
    settle();
    put_reg(REG_GRID_X, 16'd4);
    cfg_valid_i <= 1'b0;
    run_to_origin();
    run_points(sweep_sb.grid_points(), 1'b0, 1'b0);
    settle();

    // most rows with output backpressure, then shrink y mid plane
    tx_idle = 1'b0;
    hold_req = 1'b1;
    write_grid(3, 255, 3, 1'b0);
    run_points(2 * sweep_sb.dim_y() * sweep_sb.dim_z() + 20 * sweep_sb.dim_z(), 1'b1, 1'b0);
    settle();
    put_reg(REG_GRID_Y, 16'd10);
    cfg_valid_i <= 1'b0;
    tx_idle = 1'b1;
    run_to_origin();
    run_points(sweep_sb.grid_points(), 1'b0, 1'b0);
    settle();

    // most columns, then shrink z mid row
    tx_idle = 1'b0;
    hold_req = 1'b1;
    write_grid(3, 3, 127, 1'b0);
    run_points(2 * sweep_sb.dim_y() * sweep_sb.dim_z() + sweep_sb.dim_z() + 20, 1'b1, 1'b0);
    settle();
    put_reg(REG_GRID_Z, 16'd10);
    cfg_valid_i <= 1'b0;
    run_to_origin();
    run_points(sweep_sb.grid_points(), 1'b0, 1'b0);
    settle();

    while (sweep_sb.accepted < TOTAL_POINTS) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) == 0) hold_req = 1'b1;
      write_grid($urandom_range(0, 7), $urandom_range(0, 12), $urandom_range(0, 12),
                 $urandom_range(0, 5) == 0);
      repeat ($urandom_range(1, 3)) begin
        span = sweep_sb.grid_points();
        if ($urandom_range(0, 4) == 0) span = $urandom_range(1, span);
        run_points(span, !sweep_sb.at_origin() || $urandom_range(0, 1), 1'b1);
      end
      settle();
    end

    if (sweep_sb.errors == 0) begin
      $display("** jacobi_heat_stencil_3d: PASSED **");
    end else begin
      $display("** jacobi_heat_stencil_3d: FAILED **");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sweep_sb.check_point(new_temperature_o, sweep_end_o);
    end
  end

  initial begin
    #20000000;
    $display("** jacobi_heat_stencil_3d: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
hdl/jhs3d_pkg.sv
hdl/jacobi_heat_stencil_3d.sv
tb/tb_top.sv
